FILE: rtl/core/bmh_pkg.sv
// Shared types and constants for the binary min-heap block.
// No dependencies; imported by bmh_ctrl, bmh_dpath and binary_min_heap.
package bmh_pkg;

   localparam int CAPACITY_DEFAULT = 128;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LATCH,
      CMD_REJECT_FULL,
      CMD_REJECT_EMPTY,
      CMD_UP_BEGIN,
      CMD_UP_READ,
      CMD_UP_MOVE,
      CMD_UP_PLACE,
      CMD_DN_BEGIN,
      CMD_DN_LOAD,
      CMD_DN_READ,
      CMD_DN_MOVE,
      CMD_DN_PLACE,
      CMD_RSP_LOAD
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_READ,
      S_UP_CMP,
      S_DN_LOAD,
      S_DN_READ,
      S_DN_CMP,
      S_FINISH
   } state_type;

   typedef struct packed {
      cmd_type cmd;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   at_root;
      logic   up_swap;
      logic   no_child;
      logic   dn_swap;
   } dp_stat_type;

endpackage

FILE: rtl/core/bmh_ctrl.sv
// Sequencer for the heap: walks insert and delete-min through their sift steps.
// Depends on bmh_pkg; drives bmh_dpath by command, reads its status.
module bmh_ctrl
   import bmh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output dp_cmd_type  dp_cmd,
   input  dp_stat_type dp_stat
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dp_cmd.cmd = CMD_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.cmd = CMD_LATCH;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (dp_stat.op == OP_INSERT) begin
               if (dp_stat.full) begin
                  dp_cmd.cmd = CMD_REJECT_FULL;
                  state_in   = S_FINISH;
               end else begin
                  dp_cmd.cmd = CMD_UP_BEGIN;
                  state_in   = S_UP_READ;
               end
            end else begin
               if (dp_stat.empty) begin
                  dp_cmd.cmd = CMD_REJECT_EMPTY;
                  state_in   = S_FINISH;
               end else begin
                  dp_cmd.cmd = CMD_DN_BEGIN;
                  state_in   = S_DN_LOAD;
               end
            end
         end
         S_UP_READ: begin
            if (dp_stat.at_root) begin
               dp_cmd.cmd = CMD_UP_PLACE;
               state_in   = S_FINISH;
            end else begin
               dp_cmd.cmd = CMD_UP_READ;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (dp_stat.up_swap) begin
               dp_cmd.cmd = CMD_UP_MOVE;
               state_in   = S_UP_READ;
            end else begin
               dp_cmd.cmd = CMD_UP_PLACE;
               state_in   = S_FINISH;
            end
         end
         S_DN_LOAD: begin
            // last entry was the root itself: nothing left to sift
            if (dp_stat.empty) begin
               state_in = S_FINISH;
            end else begin
               dp_cmd.cmd = CMD_DN_LOAD;
               state_in   = S_DN_READ;
            end
         end
         S_DN_READ: begin
            if (dp_stat.no_child) begin
               dp_cmd.cmd = CMD_DN_PLACE;
               state_in   = S_FINISH;
            end else begin
               dp_cmd.cmd = CMD_DN_READ;
               state_in   = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (dp_stat.dn_swap) begin
               dp_cmd.cmd = CMD_DN_MOVE;
               state_in   = S_DN_READ;
            end else begin
               dp_cmd.cmd = CMD_DN_PLACE;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd.cmd = CMD_RSP_LOAD;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.cmd == CMD_RSP_LOAD) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/core/bmh_dpath.sv
// Heap datapath: entry store, moving value, position, count and result registers.
// Depends on bmh_pkg; commanded by bmh_ctrl.
module bmh_dpath
   import bmh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [0:0]         req_op,
   input  logic signed [31:0] req_value,
   input  dp_cmd_type         dp_cmd,
   output dp_stat_type        dp_stat,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed,
   output logic signed [31:0] rsp_min,
   output logic [7:0]         rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   logic signed [31:0] mem [CAPACITY];

   op_type             op_ff, op_in;
   logic signed [31:0] val_ff, val_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] root_ff, root_in;
   status_type         status_ff, status_in;
   logic signed [31:0] removed_ff, removed_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_removed_ff, rsp_removed_in;
   logic signed [31:0] rsp_min_ff, rsp_min_in;
   logic [7:0]         rsp_count_ff, rsp_count_in;
   logic signed [31:0] rd_a_ff, rd_b_ff;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic [AW-1:0]      rd_addr_a, rd_addr_b;

   logic [AW-1:0]      parent_pos;
   logic [IW-1:0]      left_idx, right_idx, count_w;
   logic               left_ok, right_ok, take_right;
   logic signed [31:0] child_val;
   logic [AW-1:0]      child_pos;
   logic [CW+7:0]      count_ext;

   // store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      op_ff          <= op_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      root_ff        <= root_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_min_ff     <= rsp_min_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign parent_pos = (pos_ff - 1'b1) >> 1;
   assign left_idx   = IW'({pos_ff, 1'b1});
   assign right_idx  = left_idx + 1'b1;
   assign count_w    = IW'(count_ff);
   assign left_ok    = left_idx < count_w;
   assign right_ok   = right_idx < count_w;
   // ties between children go left
   assign take_right = right_ok && (rd_b_ff < rd_a_ff);
   assign child_val  = take_right ? rd_b_ff : rd_a_ff;
   assign child_pos  = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
   assign count_ext  = {8'd0, count_ff};

   always_comb begin
      op_in          = op_ff;
      val_in         = val_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_min_in     = rsp_min_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = val_ff;
      rd_addr_a      = '0;
      rd_addr_b      = '0;
      unique case (dp_cmd.cmd)
         CMD_NONE: begin
         end
         CMD_LATCH: begin
            op_in      = op_type'(req_op);
            val_in     = req_value;
            status_in  = ST_DONE;
            removed_in = '0;
         end
         CMD_REJECT_FULL:  status_in = ST_FULL;
         CMD_REJECT_EMPTY: status_in = ST_EMPTY;
         CMD_UP_BEGIN: begin
            pos_in   = AW'(count_ff);
            count_in = count_ff + 1'b1;
         end
         CMD_UP_READ: rd_addr_a = parent_pos;
         CMD_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_a_ff;
            pos_in  = parent_pos;
         end
         CMD_UP_PLACE, CMD_DN_PLACE: wr_en = 1'b1;
         CMD_DN_BEGIN: begin
            removed_in = root_ff;
            count_in   = count_ff - 1'b1;
            rd_addr_a  = AW'(count_ff - 1'b1);
         end
         CMD_DN_LOAD: begin
            val_in = rd_a_ff;
            pos_in = '0;
         end
         CMD_DN_READ: begin
            rd_addr_a = left_ok ? left_idx[AW-1:0] : '0;
            rd_addr_b = right_ok ? right_idx[AW-1:0] : '0;
         end
         CMD_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = child_val;
            pos_in  = child_pos;
         end
         CMD_RSP_LOAD: begin
            rsp_status_in  = status_ff;
            rsp_removed_in = removed_ff;
            rsp_min_in     = (count_ff != '0) ? root_ff : '0;
            rsp_count_in   = count_ext[7:0];
         end
         default: begin
         end
      endcase
   end

   // shadow of entry zero, so the root is at hand without a read
   assign root_in = (wr_en && wr_addr == '0) ? wr_data : root_ff;

   assign dp_stat.op       = op_ff;
   assign dp_stat.full     = (count_ff == CW'(CAPACITY));
   assign dp_stat.empty    = (count_ff == '0);
   assign dp_stat.at_root  = (pos_ff == '0);
   assign dp_stat.up_swap  = (val_ff < rd_a_ff);
   assign dp_stat.no_child = !left_ok;
   assign dp_stat.dn_swap  = (child_val < val_ff);

   assign rsp_status  = rsp_status_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_min     = rsp_min_ff;
   assign rsp_count   = rsp_count_ff;

endmodule

FILE: rtl/core/binary_min_heap.sv
// Top level of the binary min-heap priority queue.
// Depends on bmh_pkg, bmh_ctrl and bmh_dpath.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: op; tdata: value
//   rsp      out  rsp_tvalid/rsp_tready  tuser: status; tdata: removed, min, count
//
// One request at a time. Insert climbs one level per store read and compare, stopping
// at the root or when the parent is not larger; delete-min descends one level per read
// of both children and compare; a rejected request skips the sift steps.
// Reset clears the entry count and the sequencer state and response valid flag;
// the store needs no clearing pass. A held result stalls the next request only at its final step.
module binary_min_heap
   import bmh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] removed_value, [63:32] current_min,
                                    // [71:64] entry_count
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   dp_cmd_type         dp_cmd;
   dp_stat_type        dp_stat;
   logic signed [31:0] rsp_removed, rsp_min;
   logic [7:0]         rsp_count;

   bmh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_stat    (dp_stat)
   );

   bmh_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_op      (req_tuser),
      .req_value   ($signed(req_tdata)),
      .dp_cmd      (dp_cmd),
      .dp_stat     (dp_stat),
      .rsp_status  (rsp_tuser),
      .rsp_removed (rsp_removed),
      .rsp_min     (rsp_min),
      .rsp_count   (rsp_count)
   );

   assign rsp_tdata = {rsp_count, rsp_min, rsp_removed};

endmodule
